### design/sha1bs_pkg.sv
// Shared constants for the SHA-1 byte stream hasher: command codes,
// initial chaining words, round constants and round helper functions.
// No dependencies.
package sha1bs_pkg;

    localparam int unsigned NumChain  = 5;
    localparam int unsigned NumRounds = 80;
    localparam int unsigned BlockBytes = 64;

    typedef logic [1:0]  cmd_t;
    typedef logic [31:0] word_t;

    localparam cmd_t CMD_ABSORB  = 2'd0;
    localparam cmd_t CMD_FINISH  = 2'd1;
    localparam cmd_t CMD_RESTART = 2'd2;

    localparam word_t IV0 = 32'h6745_2301;
    localparam word_t IV1 = 32'hEFCD_AB89;
    localparam word_t IV2 = 32'h98BA_DCFE;
    localparam word_t IV3 = 32'h1032_5476;
    localparam word_t IV4 = 32'hC3D2_E1F0;

    localparam word_t K0 = 32'h5A82_7999;
    localparam word_t K1 = 32'h6ED9_EBA1;
    localparam word_t K2 = 32'h8F1B_BCDC;
    localparam word_t K3 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic word_t rotl(input word_t x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // round function and constant by round number
    function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                      input word_t c, input word_t d);
        if (rnd < 7'd20)
            round_f = (b & c) | (~b & d);
        else if (rnd < 7'd40 || rnd >= 7'd60)
            round_f = b ^ c ^ d;
        else
            round_f = (b & c) | (b & d) | (c & d);
    endfunction

    function automatic word_t round_k(input logic [6:0] rnd);
        if (rnd < 7'd20)
            round_k = K0;
        else if (rnd < 7'd40)
            round_k = K1;
        else if (rnd < 7'd60)
            round_k = K2;
        else
            round_k = K3;
    endfunction

endpackage

### design/sha1_byte_stream_hasher.sv
// SHA-1 digest over a byte stream: byte window, one shared round unit
// under a small sequencer, padding and digest word output.
// Depends on sha1bs_pkg.
//
// channel  dir  tdata            tuser                   tlast
// s_       in   byte_value[7:0]  cmd[1:0]                -
// m_       out  digest_word      word_index[2:0], ok[3]  last_word
//
// Absorb shifts one byte into the window; the 64th byte of a block starts
// 80 rounds on the one round unit, then one fold into the chaining words.
// Finish pads one byte a cycle up to the block end, then rounds and fold per
// block (one or two blocks), then five words, one per accepted m_ word.
// s_tready is high only while the sequencer is idle; m_tvalid stalls hold.
// aresetn (synchronous, active low) and restart give the initial state.
module sha1_byte_stream_hasher (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // byte_value
    input  sha1bs_pkg::cmd_t        s_tuser,   // cmd
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output sha1bs_pkg::word_t       m_tdata,   // digest_word
    output logic [3:0]              m_tuser,   // word_index[2:0], ok[3]
    output logic                    m_tlast    // last_word
);
    import sha1bs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FOLD  = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [6:0] LAST_ROUND = 7'(NumRounds - 1);
    localparam logic [5:0] LAST_BYTE  = 6'(BlockBytes - 1);
    localparam logic [2:0] LAST_IDX   = 3'(NumChain - 1);

    logic [2:0]   state_reg, state_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic         fin_reg, fin_next;
    logic         fault_reg, fault_next;
    logic         closing_reg, closing_next;
    logic         len_here_reg, len_here_next;
    logic         mark_reg, mark_next;
    logic [2:0]   idx_reg, idx_next;
    logic [511:0] win_reg, win_next;
    word_t        h_reg [NumChain];
    word_t        h_next [NumChain];
    word_t        v_reg [NumChain];
    word_t        v_next [NumChain];

    logic         s_fire, m_fire;
    word_t        w_new, t_sum;
    logic [7:0]   pad_byte;
    logic [63:0]  bits_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_fire   = m_tvalid && m_tready;

    assign m_tdata  = fault_reg ? '0 : h_reg[idx_reg];
    assign m_tuser  = {~fault_reg, idx_reg};
    assign m_tlast  = (idx_reg == LAST_IDX);

    // schedule: window slot j holds w[t+j], slot 0 in the top bits
    assign w_new = rotl(win_reg[95:64] ^ win_reg[255:224] ^ win_reg[447:416]
                        ^ win_reg[511:480], 1);
    assign t_sum = rotl(v_reg[0], 5) + round_f(rnd_reg, v_reg[1], v_reg[2], v_reg[3])
                   + v_reg[4] + win_reg[511:480] + round_k(rnd_reg);
    assign bits_inc = bits_reg + 64'd8;

    always_comb begin
        if (mark_reg)
            pad_byte = PAD_MARK;
        else if (len_here_reg && fill_reg >= LEN_POS)
            pad_byte = bits_reg[63 - 8 * fill_reg[2:0] -: 8];
        else
            pad_byte = '0;
    end

    always_comb begin
        state_next    = state_reg;
        rnd_next      = rnd_reg;
        fill_next     = fill_reg;
        bits_next     = bits_reg;
        fin_next      = fin_reg;
        fault_next    = fault_reg;
        closing_next  = closing_reg;
        len_here_next = len_here_reg;
        mark_next     = mark_reg;
        idx_next      = idx_reg;
        win_next      = win_reg;
        h_next        = h_reg;
        v_next        = v_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        CMD_ABSORB: begin
                            if (fin_reg || fault_reg) begin
                                fault_next = 1'b1;
                            end else begin
                                win_next  = {win_reg[503:0], s_tdata};
                                fill_next = fill_reg + 6'd1;
                                bits_next = bits_inc;
                                if (bits_inc == '0)
                                    fault_next = 1'b1;
                                if (fill_reg == LAST_BYTE) begin
                                    state_next = ST_ROUND;
                                    rnd_next   = '0;
                                    v_next     = h_reg;
                                end
                            end
                        end
                        CMD_FINISH: begin
                            idx_next = '0;
                            if (fin_reg || fault_reg) begin
                                state_next = ST_OUT;
                            end else begin
                                state_next    = ST_PAD;
                                closing_next  = 1'b1;
                                mark_next     = 1'b1;
                                len_here_next = (fill_reg < LEN_POS);
                            end
                        end
                        CMD_RESTART: begin
                            fill_next    = '0;
                            bits_next    = '0;
                            fin_next     = 1'b0;
                            fault_next   = 1'b0;
                            closing_next = 1'b0;
                            h_next       = '{IV0, IV1, IV2, IV3, IV4};
                        end
                        default: ;
                    endcase
                end
            end
            ST_PAD: begin
                win_next  = {win_reg[503:0], pad_byte};
                mark_next = 1'b0;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == LAST_BYTE) begin
                    state_next = ST_ROUND;
                    rnd_next   = '0;
                    v_next     = h_reg;
                end
            end
            ST_ROUND: begin
                win_next = {win_reg[479:0], w_new};
                v_next   = '{t_sum, v_reg[0], rotl(v_reg[1], 30), v_reg[2], v_reg[3]};
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == LAST_ROUND)
                    state_next = ST_FOLD;
            end
            ST_FOLD: begin
                for (int i = 0; i < NumChain; i++)
                    h_next[i] = h_reg[i] + v_reg[i];
                if (!closing_reg) begin
                    state_next = ST_IDLE;
                end else if (len_here_reg) begin
                    state_next   = ST_OUT;
                    closing_next = 1'b0;
                    fin_next     = 1'b1;
                end else begin
                    state_next    = ST_PAD;
                    len_here_next = 1'b1;
                end
            end
            ST_OUT: begin
                if (m_fire) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_IDX)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rnd_reg      <= '0;
            fill_reg     <= '0;
            bits_reg     <= '0;
            fin_reg      <= 1'b0;
            fault_reg    <= 1'b0;
            closing_reg  <= 1'b0;
            len_here_reg <= 1'b0;
            mark_reg     <= 1'b0;
            idx_reg      <= '0;
            h_reg        <= '{IV0, IV1, IV2, IV3, IV4};
        end else begin
            state_reg    <= state_next;
            rnd_reg      <= rnd_next;
            fill_reg     <= fill_next;
            bits_reg     <= bits_next;
            fin_reg      <= fin_next;
            fault_reg    <= fault_next;
            closing_reg  <= closing_next;
            len_here_reg <= len_here_next;
            mark_reg     <= mark_next;
            idx_reg      <= idx_next;
            h_reg        <= h_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        v_reg   <= v_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while digest words pending");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> (rnd_reg <= LAST_ROUND))
        else $error("round counter out of range");

    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[3]) |-> (m_tdata == '0))
        else $error("faulted word not zero");

    a_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == CMD_ABSORB && !fin_reg && !fault_reg
         && fill_reg == LAST_BYTE) |=> (state_reg == ST_ROUND && rnd_reg == '0))
        else $error("full block did not start compression");

    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(fault_reg) |-> ($past(!aresetn)
            || $past(s_fire && s_tuser == CMD_RESTART)))
        else $error("fault cleared without restart");
`endif

endmodule
